// ----- src/sfk_pkg.sv -----
`default_nettype none
package sfk_pkg;

   localparam int MaxBones = 64;
   localparam int BoneBits = 6;
   localparam int RotFrac  = 14;
   localparam int RotHalf  = 1 << (RotFrac - 1);
   localparam int RotBits  = 16;
   localparam int PosBits  = 32;

   typedef struct packed {
      logic [BoneBits-1:0]       bone_index;
      logic [BoneBits-1:0]       parent_index;
      logic                      has_parent;
      logic signed [RotBits-1:0] local_rot_w;
      logic signed [RotBits-1:0] local_rot_x;
      logic signed [RotBits-1:0] local_rot_y;
      logic signed [RotBits-1:0] local_rot_z;
      logic signed [PosBits-1:0] local_pos_x;
      logic signed [PosBits-1:0] local_pos_y;
      logic signed [PosBits-1:0] local_pos_z;
   } req_type;

   typedef struct packed {
      logic [BoneBits-1:0]       out_bone_index;
      logic signed [RotBits-1:0] global_rot_w;
      logic signed [RotBits-1:0] global_rot_x;
      logic signed [RotBits-1:0] global_rot_y;
      logic signed [RotBits-1:0] global_rot_z;
      logic signed [PosBits-1:0] global_pos_x;
      logic signed [PosBits-1:0] global_pos_y;
      logic signed [PosBits-1:0] global_pos_z;
   } rsp_type;

endpackage
`default_nettype wire

// ----- src/sfk_if.sv -----
`default_nettype none
interface sfk_req_if import sfk_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sfk_rsp_if import sfk_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- src/sfk_front.sv -----
`default_nettype none
// two-entry request queue between the port and the compose engine
module sfk_front import sfk_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output req_type      out_data
);
   req_type    q_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = q_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      rd_in  = pop ? ~rd_ff : rd_ff;
      wr_in  = push ? ~wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= in_data;
   end
endmodule
`default_nettype wire

// ----- src/sfk_back.sv -----
`default_nettype none
// sequenced compose engine: one shared 32x32 multiplier, one product per step
module sfk_back import sfk_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_QUAT = 3'd2;
   localparam logic [2:0] S_MAT  = 3'd3;
   localparam logic [2:0] S_POS  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   // parent store, read data registered
   logic [4*RotBits-1:0] rot_mem [MaxBones];
   logic [PosBits-1:0]   px_mem [MaxBones];
   logic [PosBits-1:0]   py_mem [MaxBones];
   logic [PosBits-1:0]   pz_mem [MaxBones];
   logic [4*RotBits-1:0] prot_ff;
   logic [PosBits-1:0]   ppx_ff, ppy_ff, ppz_ff;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   req_type     cur_ff;
   logic signed [RotBits-1:0] pq [4];
   logic signed [RotBits-1:0] lq [4];
   logic signed [PosBits-1:0] lp [3];
   logic signed [PosBits-1:0] pp [3];
   logic signed [34:0] acc_ff, acc_in;     // quaternion sums and matrix entries
   logic signed [RotBits-1:0] gq_ff [4];
   logic signed [RotBits+3:0] m_ff [3][3]; // rounded matrix entries
   logic signed [66:0] pacc_ff, pacc_in;
   logic signed [PosBits-1:0] gp_ff [3];
   logic signed [PosBits-1:0] ma, mb;
   logic signed [63:0] prod;
   logic signed [34:0] rq;
   logic signed [RotBits+3:0] rm;
   logic signed [66:0] rp;
   logic [1:0]  qi, qk;
   logic [1:0]  mr, mc;
   logic        qneg;
   logic        done_go;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   always_comb begin
      pq[0] = prot_ff[63:48]; pq[1] = prot_ff[47:32];
      pq[2] = prot_ff[31:16]; pq[3] = prot_ff[15:0];
      lq[0] = cur_ff.local_rot_w; lq[1] = cur_ff.local_rot_x;
      lq[2] = cur_ff.local_rot_y; lq[3] = cur_ff.local_rot_z;
      lp[0] = cur_ff.local_pos_x; lp[1] = cur_ff.local_pos_y; lp[2] = cur_ff.local_pos_z;
      pp[0] = ppx_ff; pp[1] = ppy_ff; pp[2] = ppz_ff;
   end

   // operand selection per step
   always_comb begin
      qi = step_ff[3:2];
      qk = step_ff[1:0];
      mr = 2'd0; mc = 2'd0;
      qneg = 1'b0;
      ma = '0; mb = '0;
      case (state_ff)
         S_QUAT: begin
            // Hamilton product term k of component qi: parent term times local term
            ma = PosBits'(pq[qk]);
            case ({qi, qk})
               4'b0000: mb = PosBits'(lq[0]);
               4'b0001: begin mb = PosBits'(lq[1]); qneg = 1'b1; end
               4'b0010: begin mb = PosBits'(lq[2]); qneg = 1'b1; end
               4'b0011: begin mb = PosBits'(lq[3]); qneg = 1'b1; end
               4'b0100: mb = PosBits'(lq[1]);
               4'b0101: mb = PosBits'(lq[0]);
               4'b0110: mb = PosBits'(lq[3]);
               4'b0111: begin mb = PosBits'(lq[2]); qneg = 1'b1; end
               4'b1000: mb = PosBits'(lq[2]);
               4'b1001: begin mb = PosBits'(lq[3]); qneg = 1'b1; end
               4'b1010: mb = PosBits'(lq[0]);
               4'b1011: mb = PosBits'(lq[1]);
               4'b1100: mb = PosBits'(lq[3]);
               4'b1101: mb = PosBits'(lq[2]);
               4'b1110: begin mb = PosBits'(lq[1]); qneg = 1'b1; end
               4'b1111: mb = PosBits'(lq[0]);
               default: mb = '0;
            endcase
         end
         S_MAT: begin
            // step = entry*4 + term; diagonals use w w, x x, y y, z z
            case (step_ff)
               5'd0:  begin ma = PosBits'(pq[0]); mb = PosBits'(pq[0]); end
               5'd1:  begin ma = PosBits'(pq[1]); mb = PosBits'(pq[1]); end
               5'd2:  begin ma = PosBits'(pq[2]); mb = PosBits'(pq[2]); qneg = 1'b1; end
               5'd3:  begin ma = PosBits'(pq[3]); mb = PosBits'(pq[3]); qneg = 1'b1; end
               5'd4:  begin ma = PosBits'(pq[0]); mb = PosBits'(pq[0]); end
               5'd5:  begin ma = PosBits'(pq[1]); mb = PosBits'(pq[1]); qneg = 1'b1; end
               5'd6:  begin ma = PosBits'(pq[2]); mb = PosBits'(pq[2]); end
               5'd7:  begin ma = PosBits'(pq[3]); mb = PosBits'(pq[3]); qneg = 1'b1; end
               5'd8:  begin ma = PosBits'(pq[0]); mb = PosBits'(pq[0]); end
               5'd9:  begin ma = PosBits'(pq[1]); mb = PosBits'(pq[1]); qneg = 1'b1; end
               5'd10: begin ma = PosBits'(pq[2]); mb = PosBits'(pq[2]); qneg = 1'b1; end
               5'd11: begin ma = PosBits'(pq[3]); mb = PosBits'(pq[3]); end
               // off-diagonal: two products each, each product doubled as it is summed
               5'd12: begin ma = PosBits'(pq[1]); mb = PosBits'(pq[2]); end  // m01 xy
               5'd13: begin ma = PosBits'(pq[0]); mb = PosBits'(pq[3]); qneg = 1'b1; end
               5'd14: begin ma = PosBits'(pq[1]); mb = PosBits'(pq[3]); end  // m02 xz
               5'd15: begin ma = PosBits'(pq[0]); mb = PosBits'(pq[2]); end
               5'd16: begin ma = PosBits'(pq[1]); mb = PosBits'(pq[2]); end  // m10 xy
               5'd17: begin ma = PosBits'(pq[0]); mb = PosBits'(pq[3]); end
               5'd18: begin ma = PosBits'(pq[2]); mb = PosBits'(pq[3]); end  // m12 yz
               5'd19: begin ma = PosBits'(pq[0]); mb = PosBits'(pq[1]); qneg = 1'b1; end
               5'd20: begin ma = PosBits'(pq[1]); mb = PosBits'(pq[3]); end  // m20 xz
               5'd21: begin ma = PosBits'(pq[0]); mb = PosBits'(pq[2]); qneg = 1'b1; end
               5'd22: begin ma = PosBits'(pq[2]); mb = PosBits'(pq[3]); end  // m21 yz
               5'd23: begin ma = PosBits'(pq[0]); mb = PosBits'(pq[1]); end
               default: begin ma = '0; mb = '0; end
            endcase
         end
         S_POS: begin
            // step = row*3 + col
            case (step_ff)
               5'd0: begin mr = 2'd0; mc = 2'd0; end
               5'd1: begin mr = 2'd0; mc = 2'd1; end
               5'd2: begin mr = 2'd0; mc = 2'd2; end
               5'd3: begin mr = 2'd1; mc = 2'd0; end
               5'd4: begin mr = 2'd1; mc = 2'd1; end
               5'd5: begin mr = 2'd1; mc = 2'd2; end
               5'd6: begin mr = 2'd2; mc = 2'd0; end
               5'd7: begin mr = 2'd2; mc = 2'd1; end
               default: begin mr = 2'd2; mc = 2'd2; end
            endcase
            ma = PosBits'(m_ff[mr][mc]);
            mb = lp[mc];
         end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   assign prod = 64'(ma) * 64'(mb);

   // rounding helpers
   always_comb begin
      rq = (acc_ff + 35'(RotHalf)) >>> RotFrac;
      rm = (RotBits+4)'((acc_ff + 35'(RotHalf)) >>> RotFrac);
      rp = (pacc_ff + 67'(RotHalf)) >>> RotFrac;
   end

   function automatic logic signed [RotBits-1:0] sat16(input logic signed [34:0] v);
      if (v > 35'sd32767) return 16'sh7fff;
      if (v < -35'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic signed [PosBits-1:0] sat32(input logic signed [67:0] v);
      if (v > 68'sh7fffffff) return 32'sh7fffffff;
      if (v < -68'sh80000000) return 32'sh80000000;
      return v[31:0];
   endfunction

   // the response register frees the engine; it waits only if a response is still held
   assign done_go  = !rsp_valid_ff || out_ready;
   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      acc_in   = acc_ff;
      pacc_in  = pacc_ff;
      case (state_ff)
         S_IDLE: if (in_valid && in_ready) begin
            state_in = S_READ;
            step_in = '0;
         end
         S_READ: begin
            state_in = cur_ff.has_parent ? S_QUAT : S_DONE;
            step_in = '0;
            acc_in = '0;
         end
         S_QUAT: begin
            acc_in = (qk == 2'd0) ? 35'(prod) : (qneg ? acc_ff - 35'(prod) : acc_ff + 35'(prod));
            if (qk == 2'd0 && step_ff != 5'd0) acc_in = qneg ? -35'(prod) : 35'(prod);
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd16) begin
               state_in = S_MAT;
               step_in = '0;
               acc_in = '0;
            end
         end
         S_MAT: begin
            if (step_ff < 5'd12)
               acc_in = (step_ff[1:0] == 2'd0) ? (qneg ? -35'(prod) : 35'(prod))
                      : (qneg ? acc_ff - 35'(prod) : acc_ff + 35'(prod));
            else
               acc_in = (step_ff[0] == 1'b0) ? 35'(prod) <<< 1
                      : (qneg ? acc_ff - (35'(prod) <<< 1) : acc_ff + (35'(prod) <<< 1));
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd24) begin
               state_in = S_POS;
               step_in = '0;
               pacc_in = '0;
            end
         end
         S_POS: begin
            pacc_in = (mc == 2'd0) ? 67'(prod) : pacc_ff + 67'(prod);
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd9) state_in = S_DONE;
         end
         S_DONE: if (done_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // results that finish one step late (registered sum of previous step)
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && in_valid && in_ready) cur_ff <= in_data;
      if (state_ff == S_READ) begin
         prot_ff <= rot_mem[cur_ff.parent_index];
         ppx_ff  <= px_mem[cur_ff.parent_index];
         ppy_ff  <= py_mem[cur_ff.parent_index];
         ppz_ff  <= pz_mem[cur_ff.parent_index];
      end
      if (state_ff == S_QUAT && step_ff != 5'd0 && step_ff[1:0] == 2'd0)
         gq_ff[step_ff[3:2] - 2'd1] <= sat16(rq);
      if (state_ff == S_MAT && step_ff != 5'd0) begin
         if (step_ff <= 5'd12 && step_ff[1:0] == 2'd0)
            m_ff[(step_ff[3:2] - 2'd1)][(step_ff[3:2] - 2'd1)] <= rm;
         case (step_ff)
            5'd14: m_ff[0][1] <= rm;
            5'd16: m_ff[0][2] <= rm;
            5'd18: m_ff[1][0] <= rm;
            5'd20: m_ff[1][2] <= rm;
            5'd22: m_ff[2][0] <= rm;
            5'd24: m_ff[2][1] <= rm;
            default: ;
         endcase
      end
      if (state_ff == S_POS && (step_ff == 5'd3 || step_ff == 5'd6 || step_ff == 5'd9))
         gp_ff[step_ff == 5'd3 ? 2'd0 : (step_ff == 5'd6 ? 2'd1 : 2'd2)] <= sat32(
            68'(rp) + 68'(pp[step_ff == 5'd3 ? 2'd0 : (step_ff == 5'd6 ? 2'd1 : 2'd2)]));
      if (state_ff == S_DONE && done_go) begin
         rsp_ff.out_bone_index <= cur_ff.bone_index;
         if (cur_ff.has_parent) begin
            rsp_ff.global_rot_w <= gq_ff[0];
            rsp_ff.global_rot_x <= gq_ff[1];
            rsp_ff.global_rot_y <= gq_ff[2];
            rsp_ff.global_rot_z <= gq_ff[3];
            rsp_ff.global_pos_x <= gp_ff[0];
            rsp_ff.global_pos_y <= gp_ff[1];
            rsp_ff.global_pos_z <= gp_ff[2];
            rot_mem[cur_ff.bone_index] <= {gq_ff[0], gq_ff[1], gq_ff[2], gq_ff[3]};
            px_mem[cur_ff.bone_index] <= gp_ff[0];
            py_mem[cur_ff.bone_index] <= gp_ff[1];
            pz_mem[cur_ff.bone_index] <= gp_ff[2];
         end else begin
            rsp_ff.global_rot_w <= cur_ff.local_rot_w;
            rsp_ff.global_rot_x <= cur_ff.local_rot_x;
            rsp_ff.global_rot_y <= cur_ff.local_rot_y;
            rsp_ff.global_rot_z <= cur_ff.local_rot_z;
            rsp_ff.global_pos_x <= cur_ff.local_pos_x;
            rsp_ff.global_pos_y <= cur_ff.local_pos_y;
            rsp_ff.global_pos_z <= cur_ff.local_pos_z;
            rot_mem[cur_ff.bone_index] <= {cur_ff.local_rot_w, cur_ff.local_rot_x,
                                           cur_ff.local_rot_y, cur_ff.local_rot_z};
            px_mem[cur_ff.bone_index] <= cur_ff.local_pos_x;
            py_mem[cur_ff.bone_index] <= cur_ff.local_pos_y;
            pz_mem[cur_ff.bone_index] <= cur_ff.local_pos_z;
         end
      end
      acc_ff  <= acc_in;
      pacc_ff <= pacc_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (state_ff == S_DONE && done_go) rsp_valid_ff <= 1'b1;
         else if (out_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;
endmodule
`default_nettype wire

// ----- src/skeleton_forward_kinematics_unit.sv -----
`default_nettype none
// Forward kinematics for a bone tree: the sender must send each parent before
// its children, which the block does not check. Each request returns one
// response with the bone's global rotation and position. One shared 32x32
// multiplier does all the arithmetic, so a child bone keeps the compose engine
// busy while it takes the request, does one parent read, 16 quaternion products,
// 24 rotation-matrix products and 9 translation products, each group followed
// by a step that rounds its last sum, and then stores and emits. A root bone
// only takes the request, does the parent read and stores and emits. A two-entry
// request queue and a response register let the sender run ahead; the engine
// waits in its last cycle only while the previous response is still held.
module skeleton_forward_kinematics_unit import sfk_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   sfk_req_if.sink   req,
   sfk_rsp_if.source rsp
);
   logic    q_valid, q_ready;
   req_type q_data;

   sfk_front u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready), .in_data (req.payload),
      .out_valid (q_valid), .out_ready (q_ready), .out_data (q_data)
   );

   sfk_back u_back (
      .clock, .reset,
      .in_valid (q_valid), .in_ready (q_ready), .in_data (q_data),
      .out_valid (rsp.valid), .out_ready (rsp.ready), .out_data (rsp.payload)
   );
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none
module testbench;
   import sfk_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sfk_req_if req_ch ();
   sfk_rsp_if rsp_ch ();

   skeleton_forward_kinematics_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state: global transforms per bone, and which bones hold one
   logic signed [RotBits-1:0] pose_rot [MaxBones][4];
   logic signed [PosBits-1:0] pose_pos [MaxBones][3];
   bit                        pose_valid [MaxBones];

   rsp_type pose_queue[$];
   int      error_count = 0;
   int      sent_count = 0;
   bit      rsp_noidle = 1'b0;
   int      rsp_holdoff = 0;
   bit      stim_done = 1'b0;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   stim_row_type dir_rows[$];

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic longint round_frac(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(input longint v, input int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic rsp_type compose_pose(input req_type r);
      rsp_type o;
      longint w, x, y, z, a, b, c, d, acc;
      longint pp[3], lp[3], m[3][3], gq[4];
      w = 0; x = 0; y = 0; z = 0;
      pp = '{0, 0, 0};
      a = r.local_rot_w; b = r.local_rot_x; c = r.local_rot_y; d = r.local_rot_z;
      lp[0] = r.local_pos_x; lp[1] = r.local_pos_y; lp[2] = r.local_pos_z;
      o.out_bone_index = r.bone_index;
      if (!r.has_parent) begin
         o.global_rot_w = r.local_rot_w;
         o.global_rot_x = r.local_rot_x;
         o.global_rot_y = r.local_rot_y;
         o.global_rot_z = r.local_rot_z;
         o.global_pos_x = r.local_pos_x;
         o.global_pos_y = r.local_pos_y;
         o.global_pos_z = r.local_pos_z;
      end else begin
         w = pose_rot[r.parent_index][0];
         x = pose_rot[r.parent_index][1];
         y = pose_rot[r.parent_index][2];
         z = pose_rot[r.parent_index][3];
         for (int i = 0; i < 3; i++) pp[i] = pose_pos[r.parent_index][i];
         gq[0] = w*a - x*b - y*c - z*d;
         gq[1] = w*b + x*a + y*d - z*c;
         gq[2] = w*c - x*d + y*a + z*b;
         gq[3] = w*d + x*c - y*b + z*a;
         o.global_rot_w = RotBits'(clamp(round_frac(gq[0], RotFrac), RotBits));
         o.global_rot_x = RotBits'(clamp(round_frac(gq[1], RotFrac), RotBits));
         o.global_rot_y = RotBits'(clamp(round_frac(gq[2], RotFrac), RotBits));
         o.global_rot_z = RotBits'(clamp(round_frac(gq[3], RotFrac), RotBits));
         m[0][0] = w*w + x*x - y*y - z*z;
         m[0][1] = 2*(x*y - w*z);
         m[0][2] = 2*(x*z + w*y);
         m[1][0] = 2*(x*y + w*z);
         m[1][1] = w*w - x*x + y*y - z*z;
         m[1][2] = 2*(y*z - w*x);
         m[2][0] = 2*(x*z - w*y);
         m[2][1] = 2*(y*z + w*x);
         m[2][2] = w*w - x*x - y*y + z*z;
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += round_frac(m[i][j], RotFrac) * lp[j];
            gq[i] = clamp(pp[i] + round_frac(acc, RotFrac), PosBits);
         end
         o.global_pos_x = PosBits'(gq[0]);
         o.global_pos_y = PosBits'(gq[1]);
         o.global_pos_z = PosBits'(gq[2]);
      end
      pose_rot[r.bone_index][0] = o.global_rot_w;
      pose_rot[r.bone_index][1] = o.global_rot_x;
      pose_rot[r.bone_index][2] = o.global_rot_y;
      pose_rot[r.bone_index][3] = o.global_rot_z;
      pose_pos[r.bone_index][0] = o.global_pos_x;
      pose_pos[r.bone_index][1] = o.global_pos_y;
      pose_pos[r.bone_index][2] = o.global_pos_z;
      pose_valid[r.bone_index] = 1'b1;
      return o;
   endfunction

   function automatic req_type random_bone(input bit root, input bit wild);
      req_type r;
      int      cands[$];
      r = '0;
      r.bone_index = BoneBits'($urandom_range(0, MaxBones - 1));
      for (int i = 0; i < MaxBones; i++) if (pose_valid[i]) cands.push_back(i);
      r.has_parent = !root && cands.size() > 0;
      // unused parent bits still get exercised on roots
      r.parent_index = r.has_parent ? BoneBits'(cands[$urandom_range(0, cands.size() - 1)])
                                    : BoneBits'($urandom);
      if (wild) begin
         {r.local_rot_w, r.local_rot_x} = $urandom;
         {r.local_rot_y, r.local_rot_z} = $urandom;
         r.local_pos_x = $urandom;
         r.local_pos_y = $urandom;
         r.local_pos_z = $urandom;
      end else begin
         // small quaternion components and modest translation
         r.local_rot_w = RotBits'($urandom_range(0, 16384) - 8192 * $urandom_range(0, 1));
         r.local_rot_x = RotBits'(int'($urandom_range(0, 16384)) - 8192);
         r.local_rot_y = RotBits'(int'($urandom_range(0, 16384)) - 8192);
         r.local_rot_z = RotBits'(int'($urandom_range(0, 16384)) - 8192);
         r.local_pos_x = int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
         r.local_pos_y = int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
         r.local_pos_z = int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
      end
      return r;
   endfunction

   function automatic req_type make_req(input int bone, input int par, input bit hp,
                                        input int qw, input int qx, input int qy,
                                        input int qz, input int vx, input int vy,
                                        input int vz);
      req_type r;
      r.bone_index = BoneBits'(bone); r.parent_index = BoneBits'(par); r.has_parent = hp;
      r.local_rot_w = RotBits'(qw); r.local_rot_x = RotBits'(qx);
      r.local_rot_y = RotBits'(qy); r.local_rot_z = RotBits'(qz);
      r.local_pos_x = vx; r.local_pos_y = vy; r.local_pos_z = vz;
      return r;
   endfunction

   function automatic void add_row(input req_type r, input bit typed);
      stim_row_type s;
      s.item = r;
      s.typed = typed;
      s.want = {r.bone_index, r.local_rot_w, r.local_rot_x, r.local_rot_y, r.local_rot_z,
                r.local_pos_x, r.local_pos_y, r.local_pos_z};
      dir_rows.push_back(s);
   endfunction

   task automatic send_request(input req_type r, input bit idle_ok);
      while (idle_ok && $urandom_range(0, 99) < 33) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pose_queue.push_back(compose_pose(r));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pose_queue.size() != 0) @(negedge clock);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      for (int i = 0; i < MaxBones; i++) pose_valid[i] = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // roots pass through unchanged: extremes typed in
      add_row(make_req(0, 63, 0, 16384, 0, 0, 0, 0, 0, 0), 1);
      add_row(make_req(63, 0, 0, -32768, -32768, -32768, -32768,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1);
      add_row(make_req(1, 21, 0, 32767, 32767, 32767, 32767,
                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1);
      add_row(make_req(2, 42, 0, 16384, 0, 0, 0, 65536, -65536, 12345), 1);
      // children: identity parent, extreme parents (saturation), chains
      add_row(make_req(3, 2, 1, 11585, 11585, 0, 0, 65536, 131072, -65536), 0);
      add_row(make_req(4, 3, 1, 0, 0, 16384, 0, 32'h7fff_ffff, 0, 32'h8000_0000), 0);
      add_row(make_req(5, 1, 1, 32767, 32767, 32767, 32767,
                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 0);
      add_row(make_req(6, 63, 1, -32768, -32768, -32768, -32768,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0);
      add_row(make_req(7, 63, 1, 32767, -32768, 32767, -32768,
                       32'h7fff_ffff, 32'h8000_0000, 1), 0);
      add_row(make_req(8, 0, 1, -1, 1, -1, 1, -1, -1, -1), 0);
      add_row(make_req(8, 8, 1, 16384, 0, 0, 0, 0, 0, 0), 0);
      add_row(make_req(63, 5, 1, 8192, -8192, 8192, -8192, 100, -100, 7), 0);
      add_row(make_req(42, 63, 1, 16384, 0, 0, 16384, 65536, 0, 0), 0);
      add_row(make_req(21, 42, 1, 0, 16384, 0, 0, 0, 65536, 0), 0);

      foreach (dir_rows[k]) begin
         send_request(dir_rows[k].item, 1'b1);
         if (dir_rows[k].typed && pose_queue[$] != dir_rows[k].want)
            report("directed row", k, k);
      end

      // receiver holds off while the sender keeps offering
      rsp_holdoff = 200;
      for (int i = 0; i < 8; i++) send_request(random_bone($urandom_range(0, 5) == 0, 0), 0);
      wait_drained();

      for (int i = 0; i < 380; i++) begin
         rsp_noidle = (i >= 150 && i < 230);
         if (i == 300) wait_drained();
         send_request(random_bone($urandom_range(0, 9) == 0, $urandom_range(0, 4) == 0),
                      !rsp_noidle);
      end
      req_ch.valid <= 1'b0;
      stim_done = 1'b1;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_holdoff > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_holdoff <= rsp_holdoff - 1;
      end else begin
         rsp_ch.ready <= rsp_noidle || ($urandom_range(0, 99) >= 33);
      end
   end

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (pose_queue.size() == 0) begin
            report("unexpected response bone", got.out_bone_index, -1);
         end else begin
            want = pose_queue.pop_front();
            if (got.out_bone_index != want.out_bone_index)
               report("out_bone_index", got.out_bone_index, want.out_bone_index);
            if (got.global_rot_w != want.global_rot_w)
               report("global_rot_w", got.global_rot_w, want.global_rot_w);
            if (got.global_rot_x != want.global_rot_x)
               report("global_rot_x", got.global_rot_x, want.global_rot_x);
            if (got.global_rot_y != want.global_rot_y)
               report("global_rot_y", got.global_rot_y, want.global_rot_y);
            if (got.global_rot_z != want.global_rot_z)
               report("global_rot_z", got.global_rot_z, want.global_rot_z);
            if (got.global_pos_x != want.global_pos_x)
               report("global_pos_x", got.global_pos_x, want.global_pos_x);
            if (got.global_pos_y != want.global_pos_y)
               report("global_pos_y", got.global_pos_y, want.global_pos_y);
            if (got.global_pos_z != want.global_pos_z)
               report("global_pos_z", got.global_pos_z, want.global_pos_z);
         end
      end
   end

   initial begin
      wait (stim_done);
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0 && pose_queue.size() == 0) begin
         $display("** skeleton_forward_kinematics_unit: PASSED **");
      end else begin
         $display("** skeleton_forward_kinematics_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("** skeleton_forward_kinematics_unit: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
src/sfk_pkg.sv
src/sfk_if.sv
src/sfk_front.sv
src/sfk_back.sv
src/skeleton_forward_kinematics_unit.sv
sim/testbench.sv
